>>> hdl/lbfrc_pkg.sv
// Shared types, register indexes and fixed-point helpers for the LED color
// effect unit. No dependencies.
package lbfrc_pkg;

   // Frame counter width and stage count of one pipelined divider (capture + one
   // stage per quotient bit)
   localparam int FRAME_W = 32;
   localparam int DIV_LAT = FRAME_W + 1;

   // Register indexes of the write port
   localparam logic [2:0] CSR_MODE     = 3'd0;
   localparam logic [2:0] CSR_TIME_OFF = 3'd1;
   localparam logic [2:0] CSR_TIME_IN  = 3'd2;
   localparam logic [2:0] CSR_TIME_ON  = 3'd3;
   localparam logic [2:0] CSR_TIME_OUT = 3'd4;
   localparam logic [2:0] CSR_LVL_BEG  = 3'd5;
   localparam logic [2:0] CSR_LVL_END  = 3'd6;
   localparam logic [2:0] CSR_CYCLES   = 3'd7;

   // Effect modes; any other code runs the hue wheel
   localparam logic [1:0] MODE_BREATHE = 2'd0;
   localparam logic [1:0] MODE_FADE    = 2'd1;

   // Request kinds carried in tuser
   localparam logic REQ_PALETTE = 1'b0;
   localparam logic REQ_FRAME   = 1'b1;

   // Hue wheel: upper edges of the first five segments and bases of all six
   localparam logic [15:0] HUE_EDGE [5] = '{16'd10922, 16'd21846, 16'd32767,
                                            16'd43691, 16'd54612};
   localparam logic [15:0] HUE_BASE [6] = '{16'd0, 16'd10923, 16'd21845,
                                            16'd32768, 16'd43690, 16'd54613};
   // x / 43 == (x * 97542) >> 22 for every 16-bit x
   localparam logic [16:0] RECIP_43    = 17'd97542;
   localparam int          RECIP_SHIFT = 22;

   typedef enum logic [1:0] {
      PH_OFF,
      PH_IN,
      PH_ON,
      PH_OUT
   } phase_type;

   typedef enum logic [2:0] {
      OP_PASS,
      OP_D255,
      OP_D65535,
      OP_XFADE,
      OP_HUE
   } op_type;

   // x / 255 for x < 65280, one correction step
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [7:0] qh;
      logic [8:0] r;
      qh = x[15:8];
      r  = {1'b0, x[7:0]} + {1'b0, qh};
      return (r >= 9'd255) ? qh + 8'd1 : qh;
   endfunction

   // x / 65535 for x <= 255 * 65535, one correction step
   function automatic logic [7:0] div65535(input logic [23:0] x);
      logic [7:0]  qh;
      logic [16:0] r;
      qh = x[23:16];
      r  = {1'b0, x[15:0]} + {9'd0, qh};
      return (r >= 17'd65535) ? qh + 8'd1 : qh;
   endfunction

endpackage

>>> hdl/led_breathe_fade_rainbow_color_unit.sv
// Top level of the LED color effect unit: breathe, palette crossfade, hue wheel.
// Depends on lbfrc_pkg and lbfrc_div.
//
//  channel | dir | handshake             | content
//  req_    | in  | req_tvalid/req_tready | tuser kind, tdata frame/palette, tlast
//  rsp_    | out | rsp_tvalid/rsp_tready | tdata red, green, blue
//  csr_    | in  | csr_we                | csr_index, csr_wdata
//
// One item per cycle while the output is not stalled; a frame's color passes
// two ranks of bit-per-stage dividers, phase decode, palette read, and three
// scaling stages. Palette writes ride the same pipeline and reach the palette
// memory in order with frame reads. The whole pipeline advances only when
// the output register is free or being taken. Synchronous reset returns valid
// flags, palette count and settings to defaults; the palette is not cleared.
module led_breathe_fade_rainbow_color_unit #(
   parameter int PALETTE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] frame_number, [35:32] palette_index, [43:36] palette_red,
   // [51:44] palette_green, [59:52] palette_blue, [63:60] zero
   input  logic [63:0] req_tdata,
   // [0] req_type
   input  logic        req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_red, [15:8] out_green, [23:16] out_blue
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CW  = $clog2(PALETTE_DEPTH + 1);
   localparam int EW  = ((CW > 4) ? CW : 4) + 1;
   localparam int LAT = lbfrc_pkg::DIV_LAT;

   typedef struct packed {
      logic                 vld;
      logic                 frame;
      logic                 blank;
      logic                 wr;
      logic [EW-1:0]        idx;
      logic [23:0]          rgb;
      logic [CW-1:0]        cnt;
      lbfrc_pkg::phase_type phase;
   } side_type;

   typedef struct packed {
      logic                 vld;
      logic                 frame;
      logic                 blank;
      lbfrc_pkg::phase_type phase;
      logic [15:0]          lvl;
   } mem_side_type;

   typedef struct packed {
      logic               vld;
      logic               frame;
      logic               blank;
      lbfrc_pkg::op_type  op;
      logic [2:0]         seg;
      logic [2:0][23:0]   prod;
      logic [2:0][7:0]    base;
      logic [2:0]         sub;
      logic [32:0]        hv;
   } e1_type;

   typedef struct packed {
      logic             vld;
      logic             frame;
      logic             blank;
      logic             hue;
      logic [2:0][15:0] val;
   } e2_type;

   // ---------------- configuration registers ----------------
   logic [1:0]  mode_ff;
   logic [15:0] t_off_ff, t_in_ff, t_on_ff, t_out_ff;
   logic [7:0]  lvl_beg_ff, lvl_end_ff, cycles_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= lbfrc_pkg::MODE_BREATHE;
         t_off_ff   <= '0;
         t_in_ff    <= '0;
         t_on_ff    <= 16'd1;
         t_out_ff   <= '0;
         lvl_beg_ff <= '0;
         lvl_end_ff <= 8'hFF;
         cycles_ff  <= 8'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            lbfrc_pkg::CSR_MODE:     mode_ff    <= csr_wdata[1:0];
            lbfrc_pkg::CSR_TIME_OFF: t_off_ff   <= csr_wdata;
            lbfrc_pkg::CSR_TIME_IN:  t_in_ff    <= csr_wdata;
            lbfrc_pkg::CSR_TIME_ON:  t_on_ff    <= csr_wdata;
            lbfrc_pkg::CSR_TIME_OUT: t_out_ff   <= csr_wdata;
            lbfrc_pkg::CSR_LVL_BEG:  lvl_beg_ff <= csr_wdata[7:0];
            lbfrc_pkg::CSR_LVL_END:  lvl_end_ff <= csr_wdata[7:0];
            lbfrc_pkg::CSR_CYCLES:   cycles_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // derived settings
   logic [17:0] sum, edge2, edge3;
   logic [25:0] period;
   logic [7:0]  lvl_top, delta, cyc;
   logic        breathe, fade;

   always_comb begin
      edge2   = {2'b0, t_off_ff} + {2'b0, t_in_ff};
      edge3   = edge2 + {2'b0, t_on_ff};
      sum     = edge3 + {2'b0, t_out_ff};
      cyc     = (cycles_ff == 8'd0) ? 8'd1 : cycles_ff;
      period  = 26'(sum) * 26'(cyc);
      lvl_top = (lvl_end_ff < lvl_beg_ff) ? lvl_beg_ff : lvl_end_ff;
      delta   = lvl_top - lvl_beg_ff;
      breathe = (mode_ff == lbfrc_pkg::MODE_BREATHE);
      fade    = (mode_ff == lbfrc_pkg::MODE_FADE);
   end

   // ---------------- input side and palette count ----------------
   logic          adv, take;
   logic [EW-1:0] in_idx;
   logic          in_ok;
   logic [CW-1:0] pal_cnt_ff, pal_cnt_in;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign take       = req_tvalid && adv;
   assign in_idx     = EW'(req_tdata[35:32]);
   assign in_ok      = (in_idx < EW'(PALETTE_DEPTH));

   // count follows the last write (tlast) of each palette transfer, in transfer order
   always_comb begin
      pal_cnt_in = pal_cnt_ff;
      if (take && req_tuser == lbfrc_pkg::REQ_PALETTE && in_ok && req_tlast) begin
         pal_cnt_in = CW'(in_idx + EW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) pal_cnt_ff <= CW'(1);
      else       pal_cnt_ff <= pal_cnt_in;
   end

   // ---------------- first divider rank: phase position and color period ----
   logic [31:0] a_quo, b_quo;
   logic [17:0] a_rem;
   logic [25:0] b_rem;
   side_type    s1_ff [LAT];
   side_type    s1_in;

   lbfrc_div #(.NUM_W(32), .DEN_W(18)) u_div_pos (
      .clock(clock), .en(adv), .num(req_tdata[31:0]), .den(sum),
      .quo(a_quo), .rem(a_rem));

   lbfrc_div #(.NUM_W(32), .DEN_W(26)) u_div_per (
      .clock(clock), .en(adv), .num(req_tdata[31:0]), .den(period),
      .quo(b_quo), .rem(b_rem));

   always_comb begin
      s1_in       = '0;
      s1_in.vld   = take;
      s1_in.frame = (req_tuser == lbfrc_pkg::REQ_FRAME);
      s1_in.blank = (sum == 18'd0);
      s1_in.wr    = take && (req_tuser == lbfrc_pkg::REQ_PALETTE) && in_ok;
      s1_in.idx   = in_idx;
      s1_in.rgb   = 24'(req_tdata[43:36]) << 16 | 24'(req_tdata[51:44]) << 8
                    | 24'(req_tdata[59:52]);
      s1_in.cnt   = pal_cnt_in;
      s1_in.phase = lbfrc_pkg::PH_OFF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) s1_ff[i] <= '0;
      end else if (adv) begin
         s1_ff[0] <= s1_in;
         for (int i = 1; i < LAT; i++) s1_ff[i] <= s1_ff[i-1];
      end
   end

   // ---------------- phase decode ----------------
   side_type    p1_ff, p1_in;
   logic [15:0] p1_dd_ff, p1_dd_in;
   logic [31:0] p1_q_ff;

   always_comb begin
      p1_in = s1_ff[LAT-1];
      if (a_rem < {2'b0, t_off_ff}) begin
         p1_in.phase = lbfrc_pkg::PH_OFF;
         p1_dd_in    = a_rem[15:0];
      end else if (a_rem < edge2) begin
         p1_in.phase = lbfrc_pkg::PH_IN;
         p1_dd_in    = 16'(a_rem - {2'b0, t_off_ff});
      end else if (a_rem < edge3) begin
         p1_in.phase = lbfrc_pkg::PH_ON;
         p1_dd_in    = 16'(a_rem - edge2);
      end else begin
         p1_in.phase = lbfrc_pkg::PH_OUT;
         p1_dd_in    = 16'(a_rem - edge3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= '0;
      end else if (adv) begin
         p1_ff <= p1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_dd_ff <= p1_dd_in;
         p1_q_ff  <= b_quo;
      end
   end

   // ---------------- second divider rank: palette slot and ramp level --------
   logic [31:0] f_num, f_quo, c_quo;
   logic [15:0] f_den, f_rem;
   logic [15:0] step;
   logic [CW-1:0] c_rem;
   side_type    s2_ff [LAT];

   always_comb begin
      step = {delta, 8'd0} - 16'(delta);
      if (p1_ff.phase == lbfrc_pkg::PH_OUT && !breathe) begin
         f_num = {p1_dd_ff, 16'd0} - 32'(p1_dd_ff);
      end else begin
         f_num = 32'(p1_dd_ff) * 32'(step);
      end
      f_den = (p1_ff.phase == lbfrc_pkg::PH_IN) ? t_in_ff : t_out_ff;
   end

   lbfrc_div #(.NUM_W(32), .DEN_W(16)) u_div_lvl (
      .clock(clock), .en(adv), .num(f_num), .den(f_den),
      .quo(f_quo), .rem(f_rem));

   lbfrc_div #(.NUM_W(32), .DEN_W(CW)) u_div_slot (
      .clock(clock), .en(adv), .num(p1_q_ff), .den(p1_ff.cnt),
      .quo(c_quo), .rem(c_rem));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) s2_ff[i] <= '0;
      end else if (adv) begin
         s2_ff[0] <= p1_ff;
         for (int i = 1; i < LAT; i++) s2_ff[i] <= s2_ff[i-1];
      end
   end

   // ---------------- palette memory ----------------
   logic [23:0]  pal_mem [PALETTE_DEPTH];
   logic [23:0]  rd_cur_ff, rd_nxt_ff;
   logic [AW-1:0] rd_cur_addr, rd_nxt_addr;
   side_type     s2_last;
   mem_side_type m_ff, m_in;

   assign s2_last     = s2_ff[LAT-1];
   assign rd_cur_addr = c_rem[AW-1:0];
   assign rd_nxt_addr = (c_rem == s2_last.cnt - CW'(1)) ? '0
                                                         : rd_cur_addr + AW'(1);

   always_ff @(posedge clock) begin
      if (adv) begin
         if (s2_last.vld && s2_last.wr) begin
            pal_mem[s2_last.idx[AW-1:0]] <= s2_last.rgb;
         end
         rd_cur_ff <= pal_mem[rd_cur_addr];
         rd_nxt_ff <= pal_mem[rd_nxt_addr];
      end
   end

   always_comb begin
      m_in.vld   = s2_last.vld;
      m_in.frame = s2_last.frame;
      m_in.blank = s2_last.blank;
      m_in.phase = s2_last.phase;
      m_in.lvl   = f_quo[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset)    m_ff <= '0;
      else if (adv) m_ff <= m_in;
   end

   // ---------------- scaling stage 1: products and hue offset ----------------
   e1_type      e1_ff, e1_in;
   logic [15:0] lvl_ramp, hue_off;
   logic [7:0]  ch_a, ch_b;

   always_comb begin
      e1_in       = '0;
      e1_in.vld   = m_ff.vld;
      e1_in.frame = m_ff.frame;
      e1_in.blank = m_ff.blank;
      lvl_ramp    = '0;
      hue_off     = '0;
      if (m_ff.phase == lbfrc_pkg::PH_IN) begin
         lvl_ramp = m_ff.lvl + ({lvl_beg_ff, 8'd0} - 16'(lvl_beg_ff));
      end else begin
         lvl_ramp = ({lvl_top, 8'd0} - 16'(lvl_top)) - m_ff.lvl;
      end
      // hue segment from the ramp position
      priority if (m_ff.lvl <= lbfrc_pkg::HUE_EDGE[0]) e1_in.seg = 3'd0;
      else if (m_ff.lvl <= lbfrc_pkg::HUE_EDGE[1])     e1_in.seg = 3'd1;
      else if (m_ff.lvl <= lbfrc_pkg::HUE_EDGE[2])     e1_in.seg = 3'd2;
      else if (m_ff.lvl <= lbfrc_pkg::HUE_EDGE[3])     e1_in.seg = 3'd3;
      else if (m_ff.lvl <= lbfrc_pkg::HUE_EDGE[4])     e1_in.seg = 3'd4;
      else                                             e1_in.seg = 3'd5;
      hue_off  = m_ff.lvl - lbfrc_pkg::HUE_BASE[e1_in.seg];
      e1_in.hv = 33'(hue_off) * 33'(lbfrc_pkg::RECIP_43);

      unique case (m_ff.phase)
         lbfrc_pkg::PH_OFF: e1_in.op = lbfrc_pkg::OP_D255;
         lbfrc_pkg::PH_IN:  e1_in.op = lbfrc_pkg::OP_D65535;
         lbfrc_pkg::PH_ON:  e1_in.op = breathe ? lbfrc_pkg::OP_D255 : lbfrc_pkg::OP_PASS;
         lbfrc_pkg::PH_OUT: e1_in.op = breathe ? lbfrc_pkg::OP_D65535
                                      : (fade ? lbfrc_pkg::OP_XFADE : lbfrc_pkg::OP_HUE);
         default:           e1_in.op = lbfrc_pkg::OP_PASS;
      endcase

      for (int k = 0; k < 3; k++) begin
         ch_a = rd_cur_ff[23 - 8*k -: 8];
         ch_b = rd_nxt_ff[23 - 8*k -: 8];
         e1_in.base[k] = ch_a;
         e1_in.sub[k]  = (ch_a > ch_b);
         unique case (e1_in.op)
            lbfrc_pkg::OP_D255:
               e1_in.prod[k] = 24'(ch_a) * 24'((m_ff.phase == lbfrc_pkg::PH_OFF)
                                               ? lvl_beg_ff : lvl_top);
            lbfrc_pkg::OP_D65535: e1_in.prod[k] = 24'(ch_a) * 24'(lvl_ramp);
            lbfrc_pkg::OP_XFADE:
               e1_in.prod[k] = 24'((ch_a > ch_b) ? ch_a - ch_b : ch_b - ch_a)
                               * 24'(m_ff.lvl);
            default: e1_in.prod[k] = 24'(ch_a);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)    e1_ff <= '0;
      else if (adv) e1_ff <= e1_in;
   end

   // ---------------- scaling stage 2: divide by constants, hue channels -------
   e2_type          e2_ff, e2_in;
   logic [7:0]      hue_t, xf;
   logic [2:0][7:0] hue_ch;

   always_comb begin
      e2_in       = '0;
      e2_in.vld   = e1_ff.vld;
      e2_in.frame = e1_ff.frame;
      e2_in.blank = e1_ff.blank;
      e2_in.hue   = (e1_ff.op == lbfrc_pkg::OP_HUE);
      hue_t       = e1_ff.hv[lbfrc_pkg::RECIP_SHIFT +: 8];
      unique case (e1_ff.seg)
         3'd0:    hue_ch = {8'd255, 8'd0, hue_t};
         3'd1:    hue_ch = {8'd255 - hue_t, 8'd0, 8'd255};
         3'd2:    hue_ch = {8'd0, hue_t, 8'd255};
         3'd3:    hue_ch = {8'd0, 8'd255, 8'd255 - hue_t};
         3'd4:    hue_ch = {hue_t, 8'd255, 8'd0};
         default: hue_ch = {8'd255, 8'd255 - hue_t, 8'd0};
      endcase
      for (int k = 0; k < 3; k++) begin
         xf = lbfrc_pkg::div65535(e1_ff.prod[k]);
         unique case (e1_ff.op)
            lbfrc_pkg::OP_D255:
               e2_in.val[k] = 16'(lbfrc_pkg::div255(e1_ff.prod[k][15:0]));
            lbfrc_pkg::OP_D65535: e2_in.val[k] = 16'(xf);
            lbfrc_pkg::OP_XFADE:
               e2_in.val[k] = 16'(e1_ff.sub[k] ? e1_ff.base[k] - xf
                                               : e1_ff.base[k] + xf);
            lbfrc_pkg::OP_HUE: e2_in.val[k] = 16'(hue_ch[2-k]) * 16'(lvl_beg_ff);
            default:           e2_in.val[k] = 16'(e1_ff.prod[k][7:0]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)    e2_ff <= '0;
      else if (adv) e2_ff <= e2_in;
   end

   // ---------------- output register ----------------
   logic        rsp_vld_ff;
   logic [23:0] rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in = '0;
      for (int k = 0; k < 3; k++) begin
         if (!e2_ff.blank) begin
            rsp_data_in[8*k +: 8] = e2_ff.hue ? lbfrc_pkg::div255(e2_ff.val[k])
                                              : e2_ff.val[k][7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset)    rsp_vld_ff <= 1'b0;
      else if (adv) rsp_vld_ff <= e2_ff.vld && e2_ff.frame;
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      pal_cnt_ff != '0 && 32'(pal_cnt_ff) <= PALETTE_DEPTH)
      else $error("palette count out of range");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   a_slot_below_count: assert property (@(posedge clock) disable iff (reset)
      s2_last.vld && s2_last.frame |-> c_rem < s2_last.cnt)
      else $error("palette slot beyond count in use");

   a_frame_reaches_output: assert property (@(posedge clock) disable iff (reset)
      adv && e2_ff.vld && e2_ff.frame |=> rsp_tvalid)
      else $error("frame result lost at output register");
`endif

endmodule

>>> hdl/lbfrc_div.sv
// Pipelined restoring divider: one quotient bit per stage, stall by enable.
// Self-contained.
module lbfrc_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);

   // nq holds the numerator bits still to shift in, quotient bits enter low
   logic [NUM_W-1:0] nq_ff  [NUM_W+1];
   logic [DEN_W-1:0] rem_ff [NUM_W+1];
   logic [DEN_W-1:0] den_ff [NUM_W+1];

   // capture stage
   always_ff @(posedge clock) begin
      if (en) begin
         nq_ff[0]  <= num;
         rem_ff[0] <= '0;
         den_ff[0] <= den;
      end
   end

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           qbit;

      always_comb begin
         trial = {rem_ff[i], nq_ff[i][NUM_W-1]};
         diff  = trial - {1'b0, den_ff[i]};
         qbit  = (trial >= {1'b0, den_ff[i]});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_ff[i+1]  <= {nq_ff[i][NUM_W-2:0], qbit};
            den_ff[i+1] <= den_ff[i];
         end
      end
   end

   assign quo = nq_ff[NUM_W];
   assign rem = rem_ff[NUM_W];

endmodule
